// File: hw/rtl/edfq_pkg.sv
// Package for the earliest-deadline-first ready queue.
// Holds shared types, codes and the wrap-safe deadline compare; no dependencies.
`default_nettype none

package edfq_pkg;

	localparam int ID_W = 8;
	localparam int DL_W = 64;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_ERASE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE   = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_DUP    = 2'd2,
		STAT_ABSENT = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_WALK,
		FSM_COMMIT,
		FSM_REPORT
	} fsm_t;

	// Contents of one slot of the sorted chain.
	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] dl;
	} slot_t;

	// Request broadcast from the controller to every cell.
	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] dl;
		logic            commit;
	} req_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic tok;
		logic found;
		logic dup;
	} tok_t;

	// Deadline a is earlier than b when a - b, modulo 2^64, is negative.
	function automatic logic earlier(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
		logic [DL_W-1:0] diff;
		diff = a - b;
		return diff[DL_W-1];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/edfq_cell.sv
// One slot of the sorted chain: holds an entry, inspects the passing search
// token and shifts toward either neighbor on commit. Depends on edfq_pkg.
`default_nettype none

module edfq_cell
	import edfq_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire req_t  req,
	input  wire tok_t  tok_in,
	output tok_t       tok_out,
	input  wire slot_t left,
	input  wire slot_t right,
	output slot_t      slot
);

	logic            valid_q;
	logic [ID_W-1:0] id_q;
	logic [DL_W-1:0] dl_q;
	logic            after_q;
	logic            mark_q;
	tok_t            tok_q;

	logic match;
	logic hit;

	assign match = valid_q && (id_q == req.id);

	// For an insert the slot hit is the first one whose deadline is later than
	// the new one, or the first empty slot; for an erase it is the matching id.
	always_comb begin
		if (req.op == OP_INSERT) begin
			hit = !tok_in.found && (!valid_q || earlier(req.dl, dl_q));
		end else begin
			hit = !tok_in.found && match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			after_q <= 1'b0;
			mark_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			tok_q.tok   <= tok_in.tok;
			tok_q.found <= tok_in.found || hit;
			tok_q.dup   <= tok_in.dup || match;
			if (tok_in.tok) begin
				after_q <= tok_in.found || hit;
				mark_q  <= hit;
			end
			if (req.commit && after_q) begin
				if (req.op == OP_INSERT) begin
					valid_q <= mark_q ? 1'b1 : left.valid;
				end else begin
					valid_q <= right.valid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.commit && after_q) begin
			if (req.op == OP_INSERT) begin
				id_q <= mark_q ? req.id : left.id;
				dl_q <= mark_q ? req.dl : left.dl;
			end else begin
				id_q <= right.id;
				dl_q <= right.dl;
			end
		end
	end

	assign tok_out = tok_q;
	assign slot    = '{valid: valid_q, id: id_q, dl: dl_q};

endmodule

`default_nettype wire

// File: hw/rtl/edfq_ctrl.sv
// Sequencer of the ready queue: takes a request, launches the search token,
// decides the status, commits the shift and reports. Depends on edfq_pkg.
`default_nettype none

module edfq_ctrl
	import edfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            opcode,
	input  wire logic [ID_W-1:0] entry_id,
	input  wire logic [DL_W-1:0] deadline,
	input  wire tok_t            last_tok,
	output tok_t                 launch,
	output req_t                 req,
	output logic                 busy,
	output logic                 done,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     count
);

	fsm_t            state_q;
	fsm_t            state_d;
	logic            launch_q;
	op_t             op_q;
	logic [ID_W-1:0] id_q;
	logic [DL_W-1:0] dl_q;
	stat_t           status_q;
	stat_t           status_d;
	logic [CNT_W-1:0] count_q;
	logic            accept;
	logic            full;
	logic            do_commit;

	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE:   if (accept) state_d = FSM_WALK;
			FSM_WALK:   if (last_tok.tok) state_d = FSM_COMMIT;
			FSM_COMMIT: state_d = FSM_REPORT;
			FSM_REPORT: state_d = accept ? FSM_WALK : FSM_IDLE;
			default:    state_d = FSM_IDLE;
		endcase
	end

	// Full takes precedence over a duplicate id.
	always_comb begin
		if (op_q == OP_INSERT) begin
			status_d = full ? STAT_FULL : (last_tok.dup ? STAT_DUP : STAT_DONE);
		end else begin
			status_d = last_tok.found ? STAT_DONE : STAT_ABSENT;
		end
	end

	always_comb begin
		busy      = 1'b0;
		done      = 1'b0;
		do_commit = 1'b0;
		case (state_q)
			FSM_WALK:   busy = 1'b1;
			FSM_COMMIT: begin
				busy      = 1'b1;
				do_commit = (status_q == STAT_DONE);
			end
			FSM_REPORT: done = 1'b1;
			default:    busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			launch_q <= 1'b0;
			status_q <= STAT_DONE;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept;
			if (state_q == FSM_WALK && last_tok.tok) begin
				status_q <= status_d;
			end
			if (do_commit) begin
				count_q <= (op_q == OP_INSERT) ? count_q + 1'b1 : count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(opcode);
			id_q <= entry_id;
			dl_q <= deadline;
		end
	end

	assign launch = '{tok: launch_q, found: 1'b0, dup: 1'b0};
	assign req    = '{op: op_q, id: id_q, dl: dl_q, commit: do_commit};
	assign status = status_q;
	assign count  = count_q;

endmodule

`default_nettype wire

// File: hw/rtl/edf_deadline_ready_queue.sv
// Channel   | Signals                                   | Handshake
// request   | opcode, entry_id, deadline                | taken when start & !busy
// result    | status, has_entry, first_id,              | valid for one cycle while
//           | first_deadline, entry_count               | done is high, cannot stall
//
// A request passes through the walk, commit and report states before done:
// a search token walks the chain of slots one cell per cycle, then the
// commit state commits the shift and the report state presents the result.
// A new request may be accepted in the cycle that shows done.
// Reset empties the queue; slot contents are left as they are.
// Top level of the ready queue; depends on edfq_pkg, edfq_ctrl and edfq_cell.
`default_nettype none

module edf_deadline_ready_queue
	import edfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             opcode,
	input  wire logic [ID_W-1:0]  entry_id,
	input  wire logic [DL_W-1:0]  deadline,
	output logic                  done,
	output logic [1:0]            status,
	output logic                  has_entry,
	output logic [ID_W-1:0]       first_id,
	output logic [DL_W-1:0]       first_deadline,
	output logic [CNT_W-1:0]      entry_count
);

	req_t  req;
	tok_t  tok_chain [QUEUE_DEPTH+1];
	slot_t slots     [QUEUE_DEPTH];

	edfq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.opcode  (opcode),
		.entry_id(entry_id),
		.deadline(deadline),
		.last_tok(tok_chain[QUEUE_DEPTH]),
		.launch  (tok_chain[0]),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.status  (status),
		.count   (entry_count)
	);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_t left_n;
		slot_t right_n;

		if (i == 0) begin : g_first
			assign left_n = '0;
		end else begin : g_mid_l
			assign left_n = slots[i-1];
		end

		// The last slot empties on an erase.
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_n = '0;
		end else begin : g_mid_r
			assign right_n = slots[i+1];
		end

		edfq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req),
			.tok_in (tok_chain[i]),
			.tok_out(tok_chain[i+1]),
			.left   (left_n),
			.right  (right_n),
			.slot   (slots[i])
		);
	end

	assign has_entry      = slots[0].valid;
	assign first_id       = slots[0].valid ? slots[0].id : '0;
	assign first_deadline = slots[0].valid ? slots[0].dl : '0;

endmodule

`default_nettype wire

// File: hw/rtl/edfq_checker.sv
// Port-level checks of the ready queue, bound to the top level.
// Depends on edfq_pkg and edf_deadline_ready_queue.
`default_nettype none

module edfq_checker
	import edfq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire logic            done,
	input wire logic [1:0]      status,
	input wire logic            has_entry,
	input wire logic [ID_W-1:0] first_id,
	input wire logic [DL_W-1:0] first_deadline,
	input wire logic [CNT_W-1:0] entry_count
);

	// An accepted request keeps the block busy for at least the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// The result strobe is a pulse: it never stays high.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// While done is high, the queue holds something exactly when the count is nonzero.
	a_count_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (has_entry == (entry_count != '0)))
		else $error("has_entry disagrees with entry_count");

	// An empty queue reports a zero head.
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		done && !has_entry |-> (first_id == '0) && (first_deadline == '0))
		else $error("empty queue shows a nonzero head");

	// The count never exceeds the depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

endmodule

bind edf_deadline_ready_queue edfq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH),
	.CNT_W      (CNT_W)
) u_edfq_checker (.*);

`default_nettype wire

// File: tb/sv/tb_edf_deadline_ready_queue.sv
// Self-checking testbench for the earliest-deadline-first ready queue. Runs a table of
// directed requests and then random traffic, checking each result against its typed row or
// a sorted-queue model kept here. Depends on edfq_pkg and the edf_deadline_ready_queue RTL.
`timescale 1ns / 100ps

module tb_edf_deadline_ready_queue;
	import edfq_pkg::*;

	localparam int DEPTH         = 16;
	localparam int CNT_W         = $clog2(DEPTH + 1);
	localparam int NUM_DIRECTED  = 25;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int MAX_REPORTS   = 10;

	// One queue snapshot as the block reports it after a request.
	typedef struct packed {
		stat_t            status;
		logic             has;
		logic [ID_W-1:0]  id;
		logic [DL_W-1:0]  dl;
		logic [CNT_W-1:0] count;
	} queue_view_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] dl;
		logic            typed;
		queue_view_t     want;
	} request_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             opcode = 1'b0;
	logic [ID_W-1:0]  entry_id = '0;
	logic [DL_W-1:0]  deadline = '0;
	logic             done;
	logic [1:0]       status;
	logic             has_entry;
	logic [ID_W-1:0]  first_id;
	logic [DL_W-1:0]  first_deadline;
	logic [CNT_W-1:0] entry_count;

	// Model of the sorted queue: slots 0 .. held_count-1, earliest deadline first.
	logic [DL_W-1:0] held_dl [DEPTH];
	logic [ID_W-1:0] held_id [DEPTH];
	int              held_count = 0;

	queue_view_t results_due[$];
	request_t    drive_row;
	int          error_count = 0;

	// Directed requests; typed rows carry their result, the rest go through the model.
	request_t directed [NUM_DIRECTED] = '{
		'{OP_ERASE,  8'h00, 64'h0, 1'b1, '{STAT_ABSENT, 1'b0, 8'h00, 64'h0, 5'd0}},
		'{OP_INSERT, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{STAT_DONE, 1'b1, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1}},
		'{OP_INSERT, 8'h00, 64'h0000_0000_0000_0000, 1'b0, '0},
		'{OP_INSERT, 8'h80, 64'h8000_0000_0000_0000, 1'b0, '0},
		'{OP_INSERT, 8'h7F, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 8'h01, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 8'hFF, 64'h0000_0000_0000_0005, 1'b0, '0},
		'{OP_ERASE,  8'h42, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{OP_ERASE,  8'h7F, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{OP_INSERT, 8'hAA, 64'h5555_5555_5555_5555, 1'b0, '0},
		'{OP_INSERT, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{OP_INSERT, 8'h10, 64'h0000_0000_0000_0001, 1'b0, '0},
		'{OP_INSERT, 8'h11, 64'h4000_0000_0000_0000, 1'b0, '0},
		'{OP_INSERT, 8'h12, 64'hC000_0000_0000_0000, 1'b0, '0},
		'{OP_INSERT, 8'h13, 64'h0000_0000_0000_0001, 1'b0, '0},
		'{OP_INSERT, 8'h14, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{OP_INSERT, 8'h15, 64'h0000_0001_0000_0000, 1'b0, '0},
		'{OP_INSERT, 8'h16, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{OP_INSERT, 8'h17, 64'h8000_0000_0000_0001, 1'b0, '0},
		'{OP_INSERT, 8'h18, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
		'{OP_INSERT, 8'h19, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
		'{OP_INSERT, 8'h20, 64'h0000_0000_0000_0002, 1'b0, '0},
		'{OP_INSERT, 8'hFF, 64'h0000_0000_0000_0003, 1'b0, '0},
		'{OP_ERASE,  8'h10, 64'h5555_5555_5555_5555, 1'b0, '0},
		'{OP_ERASE,  8'hFF, 64'h0, 1'b0, '0}
	};

	edf_deadline_ready_queue #(
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.entry_id      (entry_id),
		.deadline      (deadline),
		.done          (done),
		.status        (status),
		.has_entry     (has_entry),
		.first_id      (first_id),
		.first_deadline(first_deadline),
		.entry_count   (entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Wrap-safe ordering: a is due before b when a - b is negative as a signed value.
	function automatic logic due_before(logic [DL_W-1:0] a, logic [DL_W-1:0] b);
		logic [DL_W-1:0] gap;
		gap = a - b;
		return gap[DL_W-1];
	endfunction

	function automatic queue_view_t apply_request(op_t op, logic [ID_W-1:0] id,
			logic [DL_W-1:0] dl);
		queue_view_t view;
		int i;
		int pos;
		int at;
		view.status = STAT_DONE;
		at = -1;
		for (i = held_count - 1; i >= 0; i--)
			if (held_id[i] == id)
				at = i;
		if (op == OP_INSERT) begin
			if (held_count >= DEPTH) begin
				view.status = STAT_FULL;
			end else if (at >= 0) begin
				view.status = STAT_DUP;
			end else begin
				// The new entry lands ahead of the first entry that it is due before,
				// so equal deadlines keep arrival order.
				pos = held_count;
				for (i = held_count - 1; i >= 0; i--)
					if (due_before(dl, held_dl[i]))
						pos = i;
				for (i = held_count; i > pos; i--) begin
					held_dl[i] = held_dl[i - 1];
					held_id[i] = held_id[i - 1];
				end
				held_dl[pos] = dl;
				held_id[pos] = id;
				held_count++;
			end
		end else if (at < 0) begin
			view.status = STAT_ABSENT;
		end else begin
			for (i = at; i < held_count - 1; i++) begin
				held_dl[i] = held_dl[i + 1];
				held_id[i] = held_id[i + 1];
			end
			held_count--;
		end
		view.has   = (held_count > 0);
		view.id    = view.has ? held_id[0] : '0;
		view.dl    = view.has ? held_dl[0] : '0;
		view.count = CNT_W'(held_count);
		return view;
	endfunction

	function automatic void check_field(string field, logic [DL_W-1:0] want, logic [DL_W-1:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		end
	endfunction

	always @(posedge clk) begin : watch
		queue_view_t want;
		queue_view_t seen;
		if (arst_n) begin
			if (done) begin
				if (results_due.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("result with no request pending: status %0d count %0d",
							status, entry_count);
				end else begin
					want = results_due.pop_front();
					check_field("status", want.status, status);
					check_field("has_entry", want.has, has_entry);
					check_field("first_id", want.id, first_id);
					check_field("first_deadline", want.dl, first_deadline);
					check_field("entry_count", want.count, entry_count);
				end
			end
			if (start && !busy) begin
				seen = apply_request(drive_row.op, drive_row.id, drive_row.dl);
				results_due.push_back(drive_row.typed ? drive_row.want : seen);
			end
		end
	end

	task automatic issue(input request_t rq);
		start     <= 1'b1;
		opcode    <= rq.op;
		entry_id  <= rq.id;
		deadline  <= rq.dl;
		drive_row <= rq;
		do @(posedge clk); while (busy);
	endtask

	initial begin : stimulus
		request_t        rq;
		logic [DL_W-1:0] now_tick;
		logic [DL_W-1:0] last_dl;
		logic [ID_W-1:0] id_pool;
		logic [ID_W-1:0] recent_ids[$];
		int              n;
		int              gap;
		int              burst_left;
		int              phase_left;
		int              pick;
		int              idx;
		logic            fill_phase;

		now_tick   = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
		last_dl    = now_tick;
		id_pool    = ID_W'($urandom_range(0, 255));
		burst_left = 0;
		phase_left = 0;
		fill_phase = 1'b1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < NUM_DIRECTED + RANDOM_ITEMS; n++) begin
			if (n < NUM_DIRECTED) begin
				rq = directed[n];
			end else begin
				// Alternate between filling and draining so that the queue runs
				// through empty, partly full and full.
				if (phase_left == 0) begin
					phase_left = $urandom_range(10, 50);
					fill_phase = !fill_phase;
				end
				phase_left--;
				now_tick += 64'($urandom_range(0, 2048));
				rq = '0;
				rq.op = ($urandom_range(0, 99) < 75) == fill_phase ? OP_INSERT : OP_ERASE;
				if (rq.op == OP_INSERT) begin
					rq.id = ($urandom_range(0, 99) < 70)
						? id_pool ^ ID_W'($urandom_range(0, 23))
						: ID_W'($urandom_range(0, 255));
					pick = $urandom_range(0, 99);
					if (pick < 75)
						rq.dl = now_tick + 64'($urandom_range(0, 65535));
					else if (pick < 85)
						rq.dl = {$urandom, $urandom};
					else if (pick < 95)
						rq.dl = last_dl;
					else
						rq.dl = now_tick - 64'($urandom_range(0, 255));
					last_dl = rq.dl;
					recent_ids.push_back(rq.id);
					if (recent_ids.size() > 40)
						void'(recent_ids.pop_front());
				end else begin
					rq.dl = {$urandom, $urandom};
					pick  = $urandom_range(0, 99);
					if (pick < 70 && recent_ids.size() > 0) begin
						idx   = $urandom_range(0, recent_ids.size() - 1);
						rq.id = recent_ids[idx];
						recent_ids.delete(idx);
					end else if (pick < 90) begin
						rq.id = id_pool ^ ID_W'($urandom_range(0, 23));
					end else begin
						rq.id = ID_W'($urandom_range(0, 255));
					end
				end
			end

			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(0, 30);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			issue(rq);
		end

		start <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/edfq_pkg.sv
hw/rtl/edfq_cell.sv
hw/rtl/edfq_ctrl.sv
hw/rtl/edf_deadline_ready_queue.sv
hw/rtl/edfq_checker.sv
tb/sv/tb_edf_deadline_ready_queue.sv
